// ===== design/mofb_pkg.sv =====
// ----------------------------------------------------------------------------
// mofb_pkg
// Shared types, constants and limit tables for the momentum observer block.
// ----------------------------------------------------------------------------
package mofb_pkg;

    localparam int JOINTS = 7;
    localparam int JW     = $clog2(JOINTS);
    localparam int JCW    = $clog2(JOINTS + 1);

    localparam logic [1:0] CFG_OBSERVER_GAIN = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd1;
    localparam logic [1:0] CFG_FEEDBACK_GAIN = 2'd2;

    localparam logic [1:0] PH_CALIB    = 2'd2;
    localparam logic [1:0] PH_FEEDBACK = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INTEG,
        ST_RESID,
        ST_CHECK,
        ST_CLOSE,
        ST_BIAS_DIV,
        ST_BIAS_WR,
        ST_SCALE,
        ST_FB_MUL,
        ST_FB_OUT,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_integ;
        logic do_resid;
        logic check_div;
        logic close_tick;
        logic div_start;
        logic bias_write;
        logic calc_scale;
        logic fb_mul;
        logic fb_out;
        logic clr_k;
        logic inc_k;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic closing;
        logic k_last;
        logic calib_phase;
        logic div_busy;
        logic out_busy;
    } sts_t;

    function automatic logic signed [31:0] reset_limit(input logic [JW-1:0] k);
        unique case (k)
            3'd0:    reset_limit = 32'sd1966080;
            3'd1:    reset_limit = 32'sd3276800;
            3'd2:    reset_limit = 32'sd3276800;
            3'd3:    reset_limit = 32'sd1966080;
            3'd4:    reset_limit = 32'sd786432;
            3'd5:    reset_limit = 32'sd786432;
            default: reset_limit = 32'sd524288;
        endcase
    endfunction

    function automatic logic signed [31:0] clamp_limit(input logic [JW-1:0] k);
        unique case (k)
            3'd0:    clamp_limit = 32'sd524288;
            3'd1:    clamp_limit = 32'sd786432;
            3'd2:    clamp_limit = 32'sd786432;
            3'd3:    clamp_limit = 32'sd524288;
            3'd4:    clamp_limit = 32'sd196608;
            3'd5:    clamp_limit = 32'sd196608;
            default: clamp_limit = 32'sd131072;
        endcase
    endfunction

    function automatic logic signed [31:0] rate_limit(input logic [JW-1:0] k);
        unique case (k)
            3'd0:    rate_limit = 32'sd5242880;
            3'd1:    rate_limit = 32'sd7864320;
            3'd2:    rate_limit = 32'sd7864320;
            3'd3:    rate_limit = 32'sd5242880;
            3'd4:    rate_limit = 32'sd2621440;
            3'd5:    rate_limit = 32'sd2621440;
            default: rate_limit = 32'sd1966080;
        endcase
    endfunction

    // round half up of a Q.16 product, then saturate to 32 bits
    function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 64'sd2147483647)
            rnd_sat = 32'sh7FFFFFFF;
        else if (r < -64'sd2147483648)
            rnd_sat = 32'sh80000000;
        else
            rnd_sat = r[31:0];
    endfunction

    function automatic logic signed [33:0] clamp_sym(input logic signed [33:0] v,
                                                     input logic signed [33:0] lim);
        if (v > lim)
            clamp_sym = lim;
        else if (v < -lim)
            clamp_sym = -lim;
        else
            clamp_sym = v;
    endfunction

endpackage

// ===== design/mofb_div.sv =====
// ----------------------------------------------------------------------------
// mofb_div
// Restoring divider, one quotient bit a cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module mofb_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] dividend,
    input  logic        [15:0] divisor,
    output logic               busy,
    output logic signed [32:0] quotient
);

    logic        [32:0] rem_reg, rem_next;
    logic        [32:0] quo_reg, quo_next;
    logic        [32:0] num_reg, num_next;
    logic        [15:0] den_reg, den_next;
    logic        [5:0]  cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               busy_reg, busy_next;
    logic        [33:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, num_reg[32]} - {18'd0, den_reg};
        if (start)
        begin
            neg_next  = dividend[32];
            num_next  = dividend[32] ? 33'(-dividend) : 33'(dividend);
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], num_reg[32]};
                quo_next = {quo_reg[31:0], 1'b0};
            end
            num_next = {num_reg[31:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        num_reg <= num_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== design/mofb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mofb_ctrl
// Sequencer for the per-joint update and the tick-closing sweeps.
// ----------------------------------------------------------------------------
module mofb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  mofb_pkg::sts_t   sts,
    output logic             in_ready,
    output mofb_pkg::cmd_t   cmd
);

    mofb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mofb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mofb_pkg::ST_IDLE:     if (in_fire) state_next = mofb_pkg::ST_INTEG;
            mofb_pkg::ST_INTEG:    state_next = mofb_pkg::ST_RESID;
            mofb_pkg::ST_RESID:    state_next = sts.closing ? mofb_pkg::ST_CHECK
                                                            : mofb_pkg::ST_IDLE;
            mofb_pkg::ST_CHECK:    if (sts.k_last) state_next = mofb_pkg::ST_CLOSE;
            mofb_pkg::ST_CLOSE:    state_next = sts.calib_phase ? mofb_pkg::ST_BIAS_DIV
                                                                : mofb_pkg::ST_SCALE;
            mofb_pkg::ST_BIAS_DIV: state_next = mofb_pkg::ST_BIAS_WR;
            mofb_pkg::ST_BIAS_WR:
                if (!sts.div_busy)
                    state_next = sts.k_last ? mofb_pkg::ST_SCALE : mofb_pkg::ST_BIAS_DIV;
            mofb_pkg::ST_SCALE:    state_next = mofb_pkg::ST_FB_MUL;
            mofb_pkg::ST_FB_MUL:   state_next = mofb_pkg::ST_FB_OUT;
            mofb_pkg::ST_FB_OUT:   state_next = mofb_pkg::ST_EMIT;
            mofb_pkg::ST_EMIT:
                if (!sts.out_busy)
                    state_next = sts.k_last ? mofb_pkg::ST_IDLE : mofb_pkg::ST_FB_MUL;
            default:               state_next = mofb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            mofb_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_fire;
            end
            mofb_pkg::ST_INTEG: cmd.do_integ = 1'b1;
            mofb_pkg::ST_RESID:
            begin
                cmd.do_resid = 1'b1;
                cmd.clr_k    = 1'b1;
            end
            mofb_pkg::ST_CHECK:
            begin
                cmd.check_div = 1'b1;
                cmd.inc_k     = 1'b1;
            end
            mofb_pkg::ST_CLOSE:
            begin
                cmd.close_tick = 1'b1;
                cmd.clr_k      = 1'b1;
            end
            mofb_pkg::ST_BIAS_DIV: cmd.div_start = 1'b1;
            mofb_pkg::ST_BIAS_WR:
                if (!sts.div_busy)
                begin
                    cmd.bias_write = 1'b1;
                    cmd.inc_k      = !sts.k_last;
                    cmd.clr_k      = sts.k_last;
                end
            mofb_pkg::ST_SCALE: cmd.calc_scale = 1'b1;
            mofb_pkg::ST_FB_MUL: cmd.fb_mul = 1'b1;
            mofb_pkg::ST_FB_OUT: cmd.fb_out = 1'b1;
            mofb_pkg::ST_EMIT:
                if (!sts.out_busy)
                    cmd.inc_k = !sts.k_last;
            default: ;
        endcase
    end

endmodule

// ===== design/mofb_dp.sv =====
// ----------------------------------------------------------------------------
// mofb_dp
// Observer, bias and feedback datapath with per-joint state.
// ----------------------------------------------------------------------------
module mofb_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mofb_pkg::cmd_t                cmd,
    output mofb_pkg::sts_t                sts,
    input  logic [22:0]                   observer_gain,
    input  logic [10:0]                   sample_period,
    input  logic [16:0]                   fb_gain,
    input  logic [2:0]                    joint,
    input  logic signed [31:0]            momentum_in,
    input  logic signed [31:0]            momentum_rate_in,
    input  logic [1:0]                    phase,
    input  logic [16:0]                   activation,
    output logic [2:0]                    out_joint,
    output logic signed [31:0]            torque_out,
    output logic                          observer_was_reset,
    output logic [15:0]                   reset_total,
    output logic                          last_joint,
    output logic                          out_valid,
    input  logic                          out_take
);

    localparam int J = mofb_pkg::JOINTS;
    localparam int W = mofb_pkg::JW;

    logic signed [31:0] integ_reg [J];
    logic signed [31:0] resid_reg [J];
    logic signed [31:0] raw_reg   [J];
    logic signed [31:0] bias_reg  [J];
    logic signed [31:0] prev_reg  [J];
    logic               ready_reg, calib_reg, div_reg, zero_raw_reg;
    logic [15:0]        nsamp_reg, rcnt_reg;
    logic [W-1:0]       j_reg, k_reg;
    logic signed [31:0] mom_reg;
    logic [1:0]         ph_reg;
    logic [16:0]        act_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] scale_reg;
    logic               ov_reg;
    logic [2:0]         oj_reg;
    logic signed [31:0] ofb_reg;
    logic               olast_reg;
    logic               div_busy;
    logic signed [32:0] div_q;
    logic signed [31:0] raw_k, abs_lim;
    logic signed [32:0] raw_abs, bias_err;
    logic signed [33:0] target, step, fb;
    logic signed [63:0] bias_sum;

    mofb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (33'(raw_k) - 33'(bias_reg[k_reg])),
        .divisor  (nsamp_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign raw_k    = zero_raw_reg ? 32'sd0 : raw_reg[k_reg];
    assign raw_abs  = raw_k[31] ? -33'(raw_k) : 33'(raw_k);
    assign abs_lim  = mofb_pkg::reset_limit(k_reg);
    assign bias_err = 33'(raw_k) - 33'(bias_reg[k_reg]);
    assign target  = mofb_pkg::clamp_sym(34'(mofb_pkg::rnd_sat(prod_reg)),
                                         34'(mofb_pkg::clamp_limit(k_reg)));
    assign step    = 34'((64'(mofb_pkg::rate_limit(k_reg)) * $signed({1'b0, sample_period})
                          + 64'sd32768) >>> 16);
    assign fb      = 34'(prev_reg[k_reg]) + mofb_pkg::clamp_sym(target - 34'(prev_reg[k_reg]), step);
    assign bias_sum = 64'(bias_reg[k_reg]) + 64'(div_q) + 64'sh8000_0000_0000 - 64'sh8000_0000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < J; i++)
            begin
                integ_reg[i] <= '0;
                resid_reg[i] <= '0;
                bias_reg[i]  <= '0;
                prev_reg[i]  <= '0;
            end
            ready_reg    <= 1'b0;
            calib_reg    <= 1'b0;
            div_reg      <= 1'b0;
            zero_raw_reg <= 1'b0;
            nsamp_reg    <= '0;
            rcnt_reg     <= '0;
            k_reg        <= '0;
            j_reg        <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (out_take)
                ov_reg <= 1'b0;
            if (cmd.load_item)
            begin
                j_reg   <= W'(joint);
                zero_raw_reg <= 1'b0;
                div_reg <= 1'b0;
            end
            if (cmd.do_integ && !ready_reg)
            begin
                integ_reg[j_reg] <= mom_reg;
                resid_reg[j_reg] <= '0;
            end
            else if (cmd.do_integ)
                integ_reg[j_reg] <= mofb_pkg::rnd_sat(prod_reg + (64'(integ_reg[j_reg]) <<< 16));
            if (cmd.do_resid && ready_reg)
                resid_reg[j_reg] <= mofb_pkg::rnd_sat(prod_reg);
            if (cmd.clr_k)
                k_reg <= '0;
            else if (cmd.inc_k)
                k_reg <= k_reg + W'(1);
            if (cmd.check_div && (raw_abs > 33'(abs_lim)))
                div_reg <= 1'b1;
            if (cmd.close_tick)
            begin
                ready_reg <= 1'b1;
                if (div_reg)
                begin
                    ready_reg    <= 1'b0;
                    zero_raw_reg <= 1'b1;
                    for (int i = 0; i < J; i++)
                        prev_reg[i] <= '0;
                    if (rcnt_reg != 16'hFFFF)
                        rcnt_reg <= rcnt_reg + 16'd1;
                end
                if (ph_reg < mofb_pkg::PH_CALIB)
                    calib_reg <= 1'b0;
                else if (!calib_reg)
                begin
                    ready_reg    <= 1'b0;
                    zero_raw_reg <= 1'b1;
                    calib_reg    <= 1'b1;
                    for (int i = 0; i < J; i++)
                    begin
                        bias_reg[i] <= '0;
                        prev_reg[i] <= '0;
                    end
                end
                if (ph_reg == mofb_pkg::PH_CALIB)
                begin
                    if (ph_reg >= mofb_pkg::PH_CALIB && !calib_reg)
                        nsamp_reg <= 16'd1;
                    else if (nsamp_reg != 16'hFFFF)
                        nsamp_reg <= nsamp_reg + 16'd1;
                end
                else if (!calib_reg && ph_reg >= mofb_pkg::PH_CALIB)
                    nsamp_reg <= '0;
            end
            if (cmd.bias_write)
                bias_reg[k_reg] <= mofb_pkg::rnd_sat((bias_sum <<< 16) - 64'sd32768);
            if (cmd.fb_out)
            begin
                if (!div_reg && act_reg != 17'd0)
                    prev_reg[k_reg] <= 32'(fb);
                else
                    prev_reg[k_reg] <= '0;
                ov_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mom_reg  <= momentum_in;
            ph_reg   <= phase;
            act_reg  <= (phase != mofb_pkg::PH_FEEDBACK) ? 17'd0
                      : (activation > 17'd65536) ? 17'd65536 : activation;
            prod_reg <= 64'($signed({1'b0, sample_period}))
                      * (64'(momentum_rate_in) + 64'(resid_reg[W'(joint)]));
        end
        if (cmd.do_integ)
            prod_reg <= 64'($signed({1'b0, observer_gain}))
                      * (64'(mom_reg) - 64'(mofb_pkg::rnd_sat(prod_reg
                         + (64'(integ_reg[j_reg]) <<< 16))));
        if (cmd.do_resid)
            raw_reg[j_reg] <= ready_reg ? mofb_pkg::rnd_sat(prod_reg) : 32'sd0;
        // drop every held raw residual on a divergence or calibration restart
        if (cmd.close_tick && (div_reg || (ph_reg >= mofb_pkg::PH_CALIB && !calib_reg)))
        begin
            for (int i = 0; i < J; i++)
                raw_reg[i] <= '0;
        end
        if (cmd.calc_scale)
            scale_reg <= 32'((64'({15'd0, act_reg}) * 64'({15'd0, fb_gain})
                              + 64'd32768) >> 16);
        if (cmd.fb_mul)
            prod_reg <= 64'(scale_reg) * 64'(bias_err);
        if (cmd.fb_out)
        begin
            oj_reg    <= 3'(k_reg);
            ofb_reg   <= (!div_reg && act_reg != 17'd0) ? 32'(fb) : 32'sd0;
            olast_reg <= (k_reg == W'(J - 1));
        end
    end

    assign sts.closing     = (j_reg == W'(J - 1));
    assign sts.k_last      = (k_reg == W'(J - 1));
    assign sts.calib_phase = (ph_reg == mofb_pkg::PH_CALIB);
    assign sts.div_busy    = div_busy;
    assign sts.out_busy    = ov_reg && !out_take;

    assign out_valid          = ov_reg;
    assign out_joint          = oj_reg;
    assign torque_out         = ofb_reg;
    assign observer_was_reset = div_reg;
    assign reset_total        = rcnt_reg;
    assign last_joint         = olast_reg;

endmodule

// ===== design/momentum_observer_force_feedback_top.sv =====
// ----------------------------------------------------------------------------
// momentum_observer_force_feedback_top
// Momentum disturbance observer with bias removal and feedback shaping.
// ----------------------------------------------------------------------------
// channel   | signals                       | beat
// s_axis    | s_tvalid/s_tready/s_tdata/tuser| one joint item
// m_axis    | m_tvalid/m_tready/m_tdata/tlast| one feedback torque
// cfg       | cfg_valid/cfg_ready/idx/data  | one register write
//
// A joint item passes through accept, integrate and residual states; the closing
// joint adds a divergence sweep, a close state, per-joint divider work in
// calibration (one quotient bit a cycle), a scale state, and multiply, output and
// emit states per torque. Reset is asynchronous, active low, and clears integrator,
// residual and bias state. A stalled output holds the sequencer in place.
// ----------------------------------------------------------------------------
module momentum_observer_force_feedback_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // joint[2:0], momentum_in[34:3], momentum_rate_in[66:35]
    input  logic [18:0] s_tuser,   // phase[1:0], activation[18:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_joint[2:0], torque[34:3], reset_total[50:35]
    output logic        m_tuser,   // observer_was_reset
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_data
);

    mofb_pkg::cmd_t cmd;
    mofb_pkg::sts_t sts;
    logic [22:0] og_reg;
    logic [10:0] sp_reg;
    logic [16:0] fg_reg;
    logic        in_fire;
    logic [2:0]  oj;
    logic signed [31:0] ofb;
    logic [15:0] orc;

    assign cfg_ready = 1'b1;

    // hold the three tuning registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            og_reg <= 23'd1235296;
            sp_reg <= 11'd328;
            fg_reg <= 17'd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mofb_pkg::CFG_OBSERVER_GAIN: og_reg <= cfg_data;
                mofb_pkg::CFG_SAMPLE_PERIOD: sp_reg <= cfg_data[10:0];
                mofb_pkg::CFG_FEEDBACK_GAIN: fg_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // drop out-of-range joints right at the accept
    assign in_fire = s_tvalid && s_tready && (s_tdata[2:0] < 3'(mofb_pkg::JOINTS));

    mofb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    mofb_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .observer_gain      (og_reg),
        .sample_period      (sp_reg),
        .fb_gain            (fg_reg),
        .joint              (s_tdata[2:0]),
        .momentum_in        (s_tdata[34:3]),
        .momentum_rate_in   (s_tdata[66:35]),
        .phase              (s_tuser[1:0]),
        .activation         (s_tuser[18:2]),
        .out_joint          (oj),
        .torque_out         (ofb),
        .observer_was_reset (m_tuser),
        .reset_total        (orc),
        .last_joint         (m_tlast),
        .out_valid          (m_tvalid),
        .out_take           (m_tvalid && m_tready)
    );

    assign m_tdata = {5'd0, orc, ofb, oj};

endmodule
